### src/stable_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stable priority queue
// Shared concurrent check forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Condition that must hold at every edge outside reset.
`define SPQ_CHECK(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("spq check failed");

// Same-cycle implication.
`define SPQ_CHECK_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spq implication failed");

// Next-cycle implication.
`define SPQ_CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spq next-cycle check failed");

`endif

### src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the priority queue cells and top level.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int ID_W       = 32;
   localparam int PAY_W      = 64;
   localparam int REQ_PRIO_W = 8;
   localparam int COUNT_W    = 5;
   localparam int STATUS_W   = 2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   localparam logic KIND_ENQ = 1'b0;
   localparam logic KIND_DEQ = 1'b1;

   // Broadcast operation to every cell in the chain.
   typedef struct packed {
      logic enq;
      logic deq;
   } cell_ctl_type;

endpackage

### src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. Keeps, loads the new entry, or shifts from
// a neighbor, depending on its own and its upper neighbor's compare.
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
#(
   parameter int PRIO_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctl_type         ctl,
   input  logic [PRIO_BITS-1:0] new_prio,
   input  logic [ID_W-1:0]      new_id,
   input  logic [PAY_W-1:0]     new_payload,
   // upper neighbor (toward head)
   input  logic                 up_lower,
   input  logic                 up_valid,
   input  logic [PRIO_BITS-1:0] up_prio,
   input  logic [ID_W-1:0]      up_id,
   input  logic [PAY_W-1:0]     up_payload,
   // lower neighbor (toward tail)
   input  logic                 dn_valid,
   input  logic [PRIO_BITS-1:0] dn_prio,
   input  logic [ID_W-1:0]      dn_id,
   input  logic [PAY_W-1:0]     dn_payload,
   // own state
   output logic                 lower,
   output logic                 valid,
   output logic [PRIO_BITS-1:0] prio,
   output logic [ID_W-1:0]      id,
   output logic [PAY_W-1:0]     payload
);

   logic                 valid_ff, valid_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [PAY_W-1:0]     payload_ff, payload_in;

   // new entry belongs at or above this slot: empty, or strictly lower priority
   assign lower = !valid_ff || (prio_ff < new_prio);

   always_comb begin
      valid_in   = valid_ff;
      prio_in    = prio_ff;
      id_in      = id_ff;
      payload_in = payload_ff;
      priority if (ctl.enq && up_lower) begin
         valid_in   = up_valid;
         prio_in    = up_prio;
         id_in      = up_id;
         payload_in = up_payload;
      end else if (ctl.enq && lower) begin
         valid_in   = 1'b1;
         prio_in    = new_prio;
         id_in      = new_id;
         payload_in = new_payload;
      end else if (ctl.deq) begin
         valid_in   = dn_valid;
         prio_in    = dn_prio;
         id_in      = dn_id;
         payload_in = dn_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff    <= prio_in;
      id_ff      <= id_in;
      payload_ff <= payload_in;
   end

   assign valid   = valid_ff;
   assign prio    = prio_ff;
   assign id      = id_ff;
   assign payload = payload_ff;

endmodule

### src/stable_priority_queue.sv
// Result: registered; appears on rsp_tvalid in the cycle after the request transfer.
// Throughput: one enqueue or dequeue per cycle while rsp_tready keeps req_tready high; every cell of the chain
// compares against the new priority and shifts in the same cycle.
// Reset: synchronous, active high; empties the queue (cell valid bits and
// count cleared), no clearing pass, ready on the first cycle after reset.
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded sorted queue, highest priority at the head, equal priorities
// leave in arrival order. Built as a chain of DEPTH cells.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_assert.svh"

module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int PRIO_BITS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // item_id[31:0], payload[95:32], priority_req[103:96]
   input  logic [0:0]   req_tuser,   // kind[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // out_id[31:0], out_payload[95:32], count[100:96],
                                     // is_empty[101], zero[103:102]
   output logic [1:0]   rsp_tuser    // status[1:0]
);

   localparam int OCC_W = $clog2(DEPTH + 1);

   logic                 req_xfer;
   logic                 kind;
   logic [ID_W-1:0]      req_id;
   logic [PAY_W-1:0]     req_payload;
   logic [PRIO_BITS-1:0] req_prio;
   logic                 full, empty, enq_ok, deq_ok;
   cell_ctl_type         ctl;

   logic                 c_lower   [DEPTH];
   logic                 c_valid   [DEPTH];
   logic [PRIO_BITS-1:0] c_prio    [DEPTH];
   logic [ID_W-1:0]      c_id      [DEPTH];
   logic [PAY_W-1:0]     c_payload [DEPTH];

   logic [OCC_W-1:0]     occ_ff, occ_in;
   logic [31:0]          occ_ext;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [PAY_W-1:0]     rsp_payload_ff, rsp_payload_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_empty_ff, rsp_empty_in;

   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign req_xfer    = req_tvalid && req_tready;
   assign kind        = req_tuser[0];
   assign req_id      = req_tdata[31:0];
   assign req_payload = req_tdata[95:32];
   assign req_prio    = PRIO_BITS'(req_tdata[103:96]);

   assign full   = c_valid[DEPTH-1];
   assign empty  = !c_valid[0];
   assign enq_ok = req_xfer && (kind == KIND_ENQ) && !full;
   assign deq_ok = req_xfer && (kind == KIND_DEQ) && !empty;

   assign ctl.enq = enq_ok;
   assign ctl.deq = deq_ok;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                 up_lower, up_valid, dn_valid;
      logic [PRIO_BITS-1:0] up_prio, dn_prio;
      logic [ID_W-1:0]      up_id, dn_id;
      logic [PAY_W-1:0]     up_payload, dn_payload;

      if (i == 0) begin : g_head
         assign up_lower   = 1'b0;
         assign up_valid   = 1'b0;
         assign up_prio    = '0;
         assign up_id      = '0;
         assign up_payload = '0;
      end else begin : g_up
         assign up_lower   = c_lower[i-1];
         assign up_valid   = c_valid[i-1];
         assign up_prio    = c_prio[i-1];
         assign up_id      = c_id[i-1];
         assign up_payload = c_payload[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign dn_valid   = 1'b0;
         assign dn_prio    = '0;
         assign dn_id      = '0;
         assign dn_payload = '0;
      end else begin : g_dn
         assign dn_valid   = c_valid[i+1];
         assign dn_prio    = c_prio[i+1];
         assign dn_id      = c_id[i+1];
         assign dn_payload = c_payload[i+1];
      end

      spq_cell #(
         .PRIO_BITS (PRIO_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_prio    (req_prio),
         .new_id      (req_id),
         .new_payload (req_payload),
         .up_lower    (up_lower),
         .up_valid    (up_valid),
         .up_prio     (up_prio),
         .up_id       (up_id),
         .up_payload  (up_payload),
         .dn_valid    (dn_valid),
         .dn_prio     (dn_prio),
         .dn_id       (dn_id),
         .dn_payload  (dn_payload),
         .lower       (c_lower[i]),
         .valid       (c_valid[i]),
         .prio        (c_prio[i]),
         .id          (c_id[i]),
         .payload     (c_payload[i])
      );
   end

   always_comb begin
      occ_in = occ_ff;
      if (enq_ok) begin
         occ_in = occ_ff + 1'b1;
      end else if (deq_ok) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   assign occ_ext = 32'(occ_in);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_empty_in   = rsp_empty_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_xfer) begin
         rsp_valid_in   = 1'b1;
         rsp_id_in      = '0;
         rsp_payload_in = '0;
         rsp_count_in   = occ_ext[COUNT_W-1:0];
         rsp_empty_in   = (occ_in == '0);
         priority if (kind == KIND_ENQ && full) begin
            rsp_status_in = ST_FULL;
         end else if (kind == KIND_DEQ && empty) begin
            rsp_status_in = ST_EMPTY;
         end else begin
            rsp_status_in = ST_OK;
            if (kind == KIND_DEQ) begin
               rsp_id_in      = c_id[0];
               rsp_payload_in = c_payload[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_empty_ff, rsp_count_ff, rsp_payload_ff, rsp_id_ff};

   // ---- checks ----
   `SPQ_CHECK(a_head_valid, clock, reset, c_valid[0] == (occ_ff != '0))
   `SPQ_CHECK(a_tail_valid, clock, reset, c_valid[DEPTH-1] == (occ_ff == OCC_W'(DEPTH)))
   `SPQ_CHECK_NEXT(a_occ_enq, clock, reset, enq_ok, occ_ff == $past(occ_ff) + 1'b1)
   `SPQ_CHECK_IMPL(a_sorted, clock, reset, c_valid[1], c_prio[0] >= c_prio[1])

endmodule
